// ===== sv/ffha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    // field widths of the request and response transfers
    localparam int REQ_SIZE_W = 13;
    localparam int DATA_OFF_W = 12;
    localparam int STATUS_W   = 3;
    localparam int MSR_W      = 7;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SPLIT = '0;
    localparam logic [MSR_W-1:0]     MSR_RESET     = 7'd1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_NULL         = 3'd2,
        ST_NOT_ALLOC    = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load;      // capture a request and restart the walk
        logic    rd_at;     // read the header at the walk pointer
        logic    rd_end;    // read the header at the merge end pointer
        logic    latch;     // keep the header just read
        logic    adv_at;    // step the walk pointer and track the free run
        logic    set_end;   // start the merge end after the current block
        logic    adv_end;   // step the merge end over a free block
        logic    wr_alloc;  // mark the chosen block used
        logic    wr_rest;   // write the header of the split-off remainder
        logic    wr_merge;  // write the merged free block
        logic    set_off;   // record the data offset of the chosen block
        logic    out_load;  // load the response register
        t_status status;    // status carried with out_load
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic op_free;   // request is a free
        logic is_null;   // free of a null pointer
        logic at_end;    // walk pointer is past the heap
        logic end_done;  // merge end pointer is past the heap
        logic fit;       // header read is free and large enough
        logic hit;       // header read belongs to the pointer to free
        logic rd_free;   // header read is marked free
        logic split;     // kept block leaves enough room to split
    } t_dp_sts;

endpackage

// ===== sv/ffha_if.sv =====
// request and response channel interfaces of the heap allocator
interface ffha_req_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [ffha_pkg::REQ_SIZE_W-1:0]   request_size;
    logic [ffha_pkg::DATA_OFF_W-1:0]   data_offset;
    logic                              null_pointer;

    modport source (output valid, op, request_size, data_offset, null_pointer, input ready);
    modport sink   (input valid, op, request_size, data_offset, null_pointer, output ready);
endinterface

interface ffha_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ffha_pkg::STATUS_W-1:0]     status;
    logic [ffha_pkg::DATA_OFF_W-1:0]   result_offset;
    logic                              heap_all_free;

    modport source (output valid, status, result_offset, heap_all_free, input ready);
    modport sink   (input valid, status, result_offset, heap_all_free, output ready);
endinterface

// ===== sv/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator with coalescing. Requests arrive one at a time on
// i_req and each gives one response on o_rsp. An allocate walks the block
// chain from the first header, each block visited taking a read of the
// header memory and an evaluate, then writes the chosen header and, on a
// split, the remainder header; a free walks to its block the same way, then
// reads forward over the following free blocks, each again with a read and
// an evaluate, and writes one header. The first header lives in flops and
// is set at reset, so there is no clearing pass and requests are taken right
// after reset. min_split_remainder sits at byte address 0 of the APB port.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ffha_req_if.sink                            i_req,
    ffha_rsp_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffha_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ffha_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ffha_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ffha_pkg::*;

    logic [MSR_W-1:0]     r_min_split;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    t_dp_cmd              cmd;
    t_dp_sts              sts;

    // configuration register
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_split <= MSR_RESET;
        end else if (cfg_wr && (reg_idx == REG_MIN_SPLIT)) begin
            r_min_split <= pwdata[MSR_W-1:0];
        end
    end

    // register read decode
    always_comb begin
        unique case (reg_idx)
            REG_MIN_SPLIT: prdata = {{(APB_DATA_W-MSR_W){1'b0}}, r_min_split};
            default:       prdata = '0;
        endcase
    end

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_req.op),
        .i_request_size  (i_req.request_size),
        .i_data_offset   (i_req.data_offset),
        .i_null_pointer  (i_req.null_pointer),
        .i_min_split     (r_min_split),
        .o_status        (o_rsp.status),
        .o_result_offset (o_rsp.result_offset),
        .o_heap_all_free (o_rsp.heap_all_free)
    );

endmodule

// ===== sv/ffha_ctrl.sv =====
// controller state machine that sequences the chain walk and header writes
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ffha_pkg::t_dp_cmd o_cmd,
    input  ffha_pkg::t_dp_sts i_sts
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,   // wait for a request
        S_RD,     // issue the header read at the walk pointer
        S_EV,     // evaluate the header read
        S_WA,     // write the chosen block header
        S_WB,     // write the remainder header
        S_FR,     // issue the header read at the merge end
        S_FE,     // evaluate a header after the freed block
        S_FW,     // write the merged block header
        S_FIN     // hand the result to the response register
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.op_free && i_sts.is_null) begin
                    n_status = ST_NULL;
                    n_state  = S_FIN;
                end else if (i_sts.at_end) begin
                    n_status = i_sts.op_free ? ST_NOT_ALLOC : ST_NO_SPACE;
                    n_state  = S_FIN;
                end else begin
                    cmd.rd_at = 1'b1;
                    n_state   = S_EV;
                end
            end
            S_EV: begin
                cmd.latch = 1'b1;
                if (!i_sts.op_free) begin
                    if (i_sts.fit) begin
                        n_state = S_WA;
                    end else begin
                        cmd.adv_at = 1'b1;
                        n_state    = S_RD;
                    end
                end else if (i_sts.hit) begin
                    if (i_sts.rd_free) begin
                        n_status = ST_ALREADY_FREE;
                        n_state  = S_FIN;
                    end else begin
                        cmd.set_end = 1'b1;
                        n_state     = S_FR;
                    end
                end else begin
                    cmd.adv_at = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_WA: begin
                cmd.wr_alloc = 1'b1;
                cmd.set_off  = 1'b1;
                n_status     = ST_OK;
                n_state      = i_sts.split ? S_WB : S_FIN;
            end
            S_WB: begin
                cmd.wr_rest = 1'b1;
                n_state     = S_FIN;
            end
            S_FR: begin
                if (i_sts.end_done) begin
                    n_state = S_FW;
                end else begin
                    cmd.rd_end = 1'b1;
                    n_state    = S_FE;
                end
            end
            S_FE: begin
                if (i_sts.rd_free) begin
                    cmd.adv_end = 1'b1;
                    n_state     = S_FR;
                end else begin
                    n_state = S_FW;
                end
            end
            S_FW: begin
                cmd.wr_merge = 1'b1;
                n_status     = ST_OK;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        cmd.status = r_status;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/ffha_dp.sv =====
// datapath: header memory, walk pointers, arithmetic and response register
module ffha_dp #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffha_pkg::t_dp_cmd               i_cmd,
    output ffha_pkg::t_dp_sts               o_sts,
    input  logic                            i_op,
    input  logic [ffha_pkg::REQ_SIZE_W-1:0] i_request_size,
    input  logic [ffha_pkg::DATA_OFF_W-1:0] i_data_offset,
    input  logic                            i_null_pointer,
    input  logic [ffha_pkg::MSR_W-1:0]      i_min_split,
    output logic [ffha_pkg::STATUS_W-1:0]   o_status,
    output logic [ffha_pkg::DATA_OFF_W-1:0] o_result_offset,
    output logic                            o_heap_all_free
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);    // header address
    localparam int LW = AW;                    // block length
    localparam int PW = AW + 2;                // chain position, may run past the heap
    localparam int CW = ((AW > REQ_SIZE_W) ? AW : REQ_SIZE_W) + 2;  // compare width
    localparam logic [PW-1:0] HDR_P    = PW'(HEADER_BYTES);
    localparam logic [PW-1:0] HEAP_P   = PW'(HEAP_BYTES);
    localparam logic [CW-1:0] HDR_C    = CW'(HEADER_BYTES);
    localparam logic [LW-1:0] HDR_L    = LW'(HEADER_BYTES);
    localparam logic [LW-1:0] FULL_LEN = LW'(HEAP_BYTES - HEADER_BYTES);

    // captured request
    logic                  r_op;
    logic                  r_null;
    logic [REQ_SIZE_W-1:0] r_size;
    logic [DATA_OFF_W-1:0] r_target;

    // walk state
    logic [PW-1:0] r_at;
    logic [PW-1:0] r_end;
    logic [PW-1:0] r_run_start;
    logic          r_run_valid;
    logic [LW-1:0] r_cur_len;
    logic [DATA_OFF_W-1:0] r_res_off;

    // header store: entry 0 in flops, the rest in memory
    logic [LW-1:0] r_len0;
    logic          r_free0;
    logic [LW:0]   r_mem [HEAP_BYTES];
    logic [LW:0]   r_rd_q;
    logic          r_rd_zero;

    // response register
    t_status               r_o_status;
    logic [DATA_OFF_W-1:0] r_o_off;
    logic                  r_o_all;

    logic [LW-1:0] rd_len;
    logic          rd_free;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW:0]   wr_data;
    logic [PW-1:0] next_at;
    logic [PW-1:0] next_end;
    logic [CW-1:0] rest_pos;
    logic [CW-1:0] off_sum;
    logic [LW-1:0] rest_len;
    logic [LW-1:0] alloc_len;
    logic          merge_run;
    logic [PW-1:0] merge_base;
    logic [PW-1:0] merge_len;
    logic          split;

    // header read data, entry 0 comes from its flops
    assign rd_len  = r_rd_zero ? r_len0 : r_rd_q[LW-1:0];
    assign rd_free = r_rd_zero ? r_free0 : r_rd_q[LW];
    assign rd_en   = i_cmd.rd_at | i_cmd.rd_end;
    assign rd_addr = i_cmd.rd_end ? r_end[AW-1:0] : r_at[AW-1:0];

    // chain arithmetic
    assign next_at    = r_at + HDR_P + PW'(rd_len);
    assign next_end   = r_end + HDR_P + PW'(rd_len);
    assign rest_pos   = CW'(r_at) + HDR_C + CW'(r_size);
    assign off_sum    = CW'(r_at) + HDR_C;
    assign rest_len   = r_cur_len - LW'(r_size) - HDR_L;
    assign split      = CW'(r_cur_len) >= (CW'(r_size) + HDR_C + CW'(i_min_split));
    assign alloc_len  = split ? LW'(r_size) : r_cur_len;
    assign merge_run  = r_run_valid && (r_run_start < r_at);
    assign merge_base = merge_run ? r_run_start : r_at;
    assign merge_len  = r_end - merge_base - HDR_P;

    // status to the controller
    always_comb begin
        o_sts.op_free  = r_op;
        o_sts.is_null  = r_null;
        o_sts.at_end   = (r_at >= HEAP_P);
        o_sts.end_done = (r_end >= HEAP_P);
        o_sts.fit      = rd_free && (CW'(rd_len) >= CW'(r_size));
        o_sts.hit      = (off_sum == CW'(r_target));
        o_sts.rd_free  = rd_free;
        o_sts.split    = split;
    end

    // header write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_at[AW-1:0];
        wr_data = {1'b0, alloc_len};
        if (i_cmd.wr_alloc) begin
            wr_en = 1'b1;
        end else if (i_cmd.wr_rest) begin
            wr_en   = 1'b1;
            wr_addr = rest_pos[AW-1:0];
            wr_data = {1'b1, rest_len};
        end else if (i_cmd.wr_merge) begin
            wr_en   = 1'b1;
            wr_addr = merge_base[AW-1:0];
            wr_data = {1'b1, merge_len[LW-1:0]};
        end
    end

    // header memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr != '0)) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_q    <= r_mem[rd_addr];
            r_rd_zero <= (rd_addr == '0);
        end
    end

    // first header, reset to one free block spanning the heap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0  <= FULL_LEN;
            r_free0 <= 1'b1;
        end else if (wr_en && (wr_addr == '0)) begin
            r_len0  <= wr_data[LW-1:0];
            r_free0 <= wr_data[LW];
        end
    end

    // request capture and walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_null      <= i_null_pointer;
            r_size      <= i_request_size;
            r_target    <= i_data_offset;
            r_at        <= '0;
            r_run_start <= '0;
            r_run_valid <= 1'b1;
            r_res_off   <= '0;
        end
        if (i_cmd.adv_at) begin
            r_at <= next_at;
            if (rd_free) begin
                if (!r_run_valid) begin
                    r_run_start <= r_at;
                    r_run_valid <= 1'b1;
                end
            end else begin
                r_run_valid <= 1'b0;
            end
        end
        if (i_cmd.latch) begin
            r_cur_len <= rd_len;
        end
        if (i_cmd.set_end) begin
            r_end <= next_at;
        end else if (i_cmd.adv_end) begin
            r_end <= next_end;
        end
        if (i_cmd.set_off) begin
            r_res_off <= off_sum[DATA_OFF_W-1:0];
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.status;
            r_o_off    <= (i_cmd.status == ST_OK) ? r_res_off : '0;
            r_o_all    <= (r_len0 == FULL_LEN) && r_free0;
        end
    end

    assign o_status        = r_o_status;
    assign o_result_offset = r_o_off;
    assign o_heap_all_free = r_o_all;

endmodule

// ===== sv/ffha_checker.sv =====
// port-level checks of the heap allocator and their binding
module ffha_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ffha_pkg::STATUS_W-1:0]   i_status,
    input logic [ffha_pkg::DATA_OFF_W-1:0] i_result_offset
);
    import ffha_pkg::*;

    // a pending response stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("response dropped before transfer");

    // a request transfer starts a walk, so no request is taken next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while a walk is in progress");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_NO_SPACE ||
                         i_status == ST_NULL || i_status == ST_NOT_ALLOC ||
                         i_status == ST_ALREADY_FREE))
        else $error("undefined status code");

    // the offset is zero for every failing request
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_OK)) |-> (i_result_offset == '0))
        else $error("nonzero offset on a failed request");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_result_offset (o_rsp.result_offset)
);

// ===== test/tb_first_fit_heap_allocator_unit.sv =====
// testbench of the first-fit heap allocator: directed table, then random traffic
module tb_first_fit_heap_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int HEAP_DATA    = HEAP_BYTES - HEADER_BYTES;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [APB_ADDR_W-1:0] MSR_ADDR = {REG_MIN_SPLIT, 2'b00};

    localparam int DIR_ROWS     = 21;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 241;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int SETTLE_END   = 32;

    typedef struct packed {
        logic                  op;
        logic [REQ_SIZE_W-1:0] size;
        logic [DATA_OFF_W-1:0] offset;
        logic                  null_ptr;
    } t_heap_req;

    typedef struct packed {
        t_status               status;
        logic [DATA_OFF_W-1:0] offset;
        logic                  all_free;
    } t_heap_reply;

    typedef struct packed {
        t_heap_req   req;
        logic        fixed;   // reply below is typed in
        t_heap_reply reply;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ffha_req_if req_if ();
    ffha_rsp_if rsp_if ();

    first_fit_heap_allocator_unit #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted heap: header entries by header byte offset
    int unsigned heap_len [HEAP_BYTES];
    bit          heap_free [HEAP_BYTES];
    int unsigned split_min;

    t_heap_reply           reply_q [$];
    logic [DATA_OFF_W-1:0] live_ptrs [$];
    logic [DATA_OFF_W-1:0] freed_ptrs [$];

    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_kicks = 0;

    // short table: extremes, error codes, zero size, merges before and after
    t_dir_row dir_table [DIR_ROWS] = '{
        {OP_ALLOC, 13'd4096, 12'd0,   1'b0, 1'b1, ST_NO_SPACE,     12'd0, 1'b1},
        {OP_FREE,  13'd0,    12'd0,   1'b1, 1'b1, ST_NULL,         12'd0, 1'b1},
        {OP_FREE,  13'd0,    12'd8,   1'b0, 1'b1, ST_ALREADY_FREE, 12'd0, 1'b1},
        {OP_FREE,  13'd0,    12'hfff, 1'b0, 1'b1, ST_NOT_ALLOC,    12'd0, 1'b1},
        {OP_ALLOC, 13'd4088, 12'd0,   1'b0, 1'b1, ST_OK,           12'd8, 1'b0},
        {OP_ALLOC, 13'd0,    12'd0,   1'b0, 1'b1, ST_NO_SPACE,     12'd0, 1'b0},
        {OP_FREE,  13'd0,    12'd8,   1'b0, 1'b1, ST_OK,           12'd0, 1'b1},
        {OP_ALLOC, 13'd0,    12'd0,   1'b0, 1'b1, ST_OK,           12'd8, 1'b0},
        {OP_ALLOC, 13'd0,    12'hfff, 1'b1, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_ALLOC, 13'd100,  12'd0,   1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_ALLOC, 13'h0aaa, 12'h555, 1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_ALLOC, 13'h0555, 12'haaa, 1'b1, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd0,    12'd16,  1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd0,    12'd16,  1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd0,    12'd24,  1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd0,    12'd8,   1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd0,    12'h555, 1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd4096, 12'hfff, 1'b1, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'd4096, 12'd132, 1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_ALLOC, 13'd4088, 12'h555, 1'b0, 1'b0, ST_OK,           12'd0, 1'b0},
        {OP_FREE,  13'h0aaa, 12'd8,   1'b0, 1'b0, ST_OK,           12'd0, 1'b0}
    };

    // first fit walk, split when the leftover is big enough
    function automatic t_heap_reply heap_alloc(int unsigned size);
        t_heap_reply r;
        int unsigned at;
        int unsigned len;
        int unsigned rest;
        r.status   = ST_NO_SPACE;
        r.offset   = '0;
        r.all_free = 1'b0;
        at = 0;
        while (at < HEAP_BYTES) begin
            len = heap_len[at];
            if (heap_free[at] && len >= size) begin
                heap_free[at] = 1'b0;
                if (len >= size + HEADER_BYTES + split_min) begin
                    rest = at + HEADER_BYTES + size;
                    heap_len[at] = size;
                    if (rest < HEAP_BYTES) begin
                        heap_free[rest] = 1'b1;
                        heap_len[rest]  = len - size - HEADER_BYTES;
                    end
                end
                r.status = ST_OK;
                r.offset = DATA_OFF_W'(at + HEADER_BYTES);
                return r;
            end
            at = at + HEADER_BYTES + len;
        end
        return r;
    endfunction

    // find the block, mark it free, merge with free runs on both sides
    function automatic t_status heap_release(int unsigned target);
        int unsigned at;
        int unsigned run_start;
        int unsigned merge_end;
        bit          run_ok;
        bit          found;
        at        = 0;
        run_start = 0;
        run_ok    = 1'b1;
        found     = 1'b0;
        while (at < HEAP_BYTES && !found) begin
            if (at + HEADER_BYTES == target) begin
                found = 1'b1;
            end else begin
                if (heap_free[at]) begin
                    if (!run_ok) begin
                        run_start = at;
                        run_ok    = 1'b1;
                    end
                end else begin
                    run_ok = 1'b0;
                end
                at = at + HEADER_BYTES + heap_len[at];
            end
        end
        if (!found)
            return ST_NOT_ALLOC;
        if (heap_free[at])
            return ST_ALREADY_FREE;
        heap_free[at] = 1'b1;
        merge_end = at;
        do begin
            merge_end = merge_end + HEADER_BYTES + heap_len[merge_end];
        end while (merge_end < HEAP_BYTES && heap_free[merge_end]);
        if (run_ok && run_start < at)
            heap_len[run_start] = merge_end - run_start - HEADER_BYTES;
        else
            heap_len[at] = merge_end - at - HEADER_BYTES;
        return ST_OK;
    endfunction

    // one request applied to the predicted heap
    function automatic t_heap_reply heap_apply(t_heap_req rq);
        t_heap_reply r;
        r.status   = ST_OK;
        r.offset   = '0;
        r.all_free = 1'b0;
        if (rq.op == OP_ALLOC)
            r = heap_alloc(rq.size);
        else if (rq.null_ptr)
            r.status = ST_NULL;
        else
            r.status = heap_release(rq.offset);
        r.all_free = (heap_len[0] == HEAP_DATA) && heap_free[0];
        return r;
    endfunction

    // mostly frees of live pointers and allocs, some broken frees
    function automatic t_heap_req pick_req();
        t_heap_req   rq;
        int unsigned alloc_pct;
        int unsigned pick;
        rq.op       = OP_ALLOC;
        rq.size     = REQ_SIZE_W'($urandom_range(4096));
        rq.offset   = DATA_OFF_W'($urandom_range(4095));
        rq.null_ptr = 1'($urandom_range(1));
        if ($urandom_range(99) < 12) begin
            rq.op = OP_FREE;
            case ($urandom_range(3))
                0: rq.null_ptr = 1'b1;
                1: rq.null_ptr = 1'b0;
                2: begin
                    rq.null_ptr = 1'b0;
                    if (freed_ptrs.size() > 0)
                        rq.offset = freed_ptrs[$urandom_range(freed_ptrs.size() - 1)];
                end
                default: begin
                    rq.null_ptr = 1'b0;
                    if (live_ptrs.size() > 0)
                        rq.offset = DATA_OFF_W'(
                            live_ptrs[$urandom_range(live_ptrs.size() - 1)]
                            + $urandom_range(7, 1));
                end
            endcase
            return rq;
        end
        if (live_ptrs.size() < 6)
            alloc_pct = 80;
        else if (live_ptrs.size() > 40)
            alloc_pct = 20;
        else
            alloc_pct = 50;
        if (live_ptrs.size() == 0 || $urandom_range(99) < alloc_pct) begin
            pick = $urandom_range(99);
            if (pick < 60)
                rq.size = REQ_SIZE_W'($urandom_range(32));
            else if (pick < 85)
                rq.size = REQ_SIZE_W'($urandom_range(256, 33));
            else if (pick < 95)
                rq.size = REQ_SIZE_W'($urandom_range(1024, 257));
            else
                rq.size = REQ_SIZE_W'($urandom_range(4096, 1025));
        end else begin
            rq.op       = OP_FREE;
            rq.null_ptr = 1'b0;
            rq.offset   = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
        end
        return rq;
    endfunction

    // offer one request, predict on its transfer, track pointers
    task automatic send_req(t_heap_req rq, logic fixed, t_heap_reply fixed_reply);
        t_heap_reply r;
        int          idx;
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= rq.op;
        req_if.request_size <= rq.size;
        req_if.data_offset  <= rq.offset;
        req_if.null_pointer <= rq.null_ptr;
        do @(posedge i_clk); while (!req_if.ready);
        r = heap_apply(rq);
        reply_q.push_back(fixed ? fixed_reply : r);
        if (r.status == ST_OK && rq.op == OP_ALLOC)
            live_ptrs.push_back(r.offset);
        if (r.status == ST_OK && rq.op == OP_FREE) begin
            idx = 0;
            while (idx < live_ptrs.size() && live_ptrs[idx] != rq.offset)
                idx++;
            if (idx < live_ptrs.size())
                live_ptrs.delete(idx);
            freed_ptrs.push_back(rq.offset);
            if (freed_ptrs.size() > 16)
                freed_ptrs.delete(0);
        end
    endtask

    // sender stops until every reply is in
    task automatic wait_replies();
        req_if.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write then read back of min_split_remainder
    task automatic set_min_split(logic [MSR_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MSR_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        split_min = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DATA_W'(v)) begin
            $error("min_split_remainder expected %0d actual %0d", v, rd);
            errors++;
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // response ready: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_kicks != hold_seen) begin
                hold_seen = hold_kicks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each response transfer with the oldest predicted reply
    always @(posedge i_clk) begin : rsp_check
        t_heap_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (reply_q.size() == 0) begin
                $error("response transfer with none outstanding: status %0d offset %0d",
                       rsp_if.status, rsp_if.result_offset);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.result_offset !== want.offset) begin
                    $error("result_offset expected %0d actual %0d",
                           want.offset, rsp_if.result_offset);
                    errors++;
                end
                if (rsp_if.heap_all_free !== want.all_free) begin
                    $error("heap_all_free expected %0d actual %0d",
                           want.all_free, rsp_if.heap_all_free);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial begin
        t_heap_reply none;
        logic [MSR_W-1:0] msr_val;
        none = '0;
        heap_len[0]  = HEAP_DATA;
        heap_free[0] = 1'b1;
        split_min    = MSR_RESET;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_ALLOC;
        req_if.request_size <= '0;
        req_if.data_offset  <= '0;
        req_if.null_pointer <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_table[i])
            send_req(dir_table[i].req, dir_table[i].fixed, dir_table[i].reply);

        // random phases, each setting its split value and idling mode
        for (int p = 0; p < PHASES; p++) begin
            wait_replies();
            case (p)
                0, 5: msr_val = '0;
                1, 4: msr_val = 7'd64;
                2: msr_val = MSR_RESET;
                default: msr_val = MSR_W'($urandom_range(64));
            endcase
            set_min_split(msr_val);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 47;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 47;
                end
                default: begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 40)
                    hold_kicks <= hold_kicks + 1;
                send_req(pick_req(), 1'b0, none);
            end
        end

        wait_replies();
        repeat (SETTLE_END) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
